// File: hdl/dropout_run_area_filter_accumulator_defines.svh
// Assertion helpers used by the checker file.
`ifndef DROPOUT_RUN_AREA_FILTER_ACCUMULATOR_DEFINES_SVH
`define DROPOUT_RUN_AREA_FILTER_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DRAFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("drafa assertion failed");

// next-cycle implication, disabled while reset is low
`define DRAFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("drafa assertion failed");

`endif

// File: hdl/drafa_pkg.sv
`default_nettype none

package drafa_pkg;

    localparam int START_BITS       = 22;
    localparam int LINE_SAMPLE_BITS = 12;

    localparam int FRAME_BITS    = 24;
    localparam int LEN_BITS      = 16;
    localparam int LINE_BITS     = 16;
    localparam int LAST_BITS     = LEN_BITS + 1;
    localparam int RUNS_BITS     = 16;
    localparam int TOTAL_BITS    = 40;
    localparam int CFG_DATA_BITS = LINE_SAMPLE_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CNT_BITS      = $clog2(START_BITS + 1);

    localparam logic [LINE_SAMPLE_BITS-1:0] SPL_RESET = LINE_SAMPLE_BITS'(910);

    typedef logic [START_BITS-1:0]       t_start;
    typedef logic [LINE_SAMPLE_BITS-1:0] t_sample;
    typedef logic [CFG_DATA_BITS-1:0]    t_cfg_data;
    typedef logic [FRAME_BITS-1:0]       t_frame;
    typedef logic [LEN_BITS-1:0]         t_len;
    typedef logic [LINE_BITS-1:0]        t_line;
    typedef logic [LAST_BITS-1:0]        t_last;
    typedef logic [RUNS_BITS-1:0]        t_runs;
    typedef logic [TOTAL_BITS-1:0]       t_total;
    typedef logic [CNT_BITS-1:0]         t_cnt;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SAMPLES_PER_LINE  = 3'd0,
        CFG_FIRST_ACTIVE_LINE = 3'd1,
        CFG_LAST_ACTIVE_LINE  = 3'd2,
        CFG_ACTIVE_START      = 3'd3,
        CFG_ACTIVE_END        = 3'd4,
        CFG_VISIBLE_MODE      = 3'd5,
        CFG_COLLECT_DETAIL    = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        REQ_RUN       = 1'b0,
        REQ_FRAME_END = 1'b1
    } t_req;

    typedef enum logic {
        KIND_DETAIL = 1'b0,
        KIND_STATS  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FILTER,
        ST_COMMIT
    } t_state;

    // divider handoff
    typedef struct packed {
        logic    done;
        t_start  quo;
        t_sample rem;
    } t_div_res;

endpackage

`default_nettype wire

// File: hdl/drafa_if.sv
`default_nettype none

interface drafa_in_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    drafa_pkg::t_frame   frame_id;
    drafa_pkg::t_start   run_start;
    drafa_pkg::t_len     run_length;

    modport source (output valid, req_type, frame_id, run_start, run_length,
                    input ready);
    modport sink   (input valid, req_type, frame_id, run_start, run_length,
                    output ready);
endinterface

interface drafa_out_if;
    logic                valid;
    logic                ready;
    logic                result_kind;
    drafa_pkg::t_frame   out_frame;
    drafa_pkg::t_line    line_index;
    drafa_pkg::t_sample  first_sample;
    drafa_pkg::t_last    last_sample;
    drafa_pkg::t_len     kept_length;
    drafa_pkg::t_runs    frame_runs;
    drafa_pkg::t_total   frame_total;
    logic                has_dropouts;

    modport source (output valid, result_kind, out_frame, line_index, first_sample,
                    last_sample, kept_length, frame_runs, frame_total, has_dropouts,
                    input ready);
    modport sink   (input valid, result_kind, out_frame, line_index, first_sample,
                    last_sample, kept_length, frame_runs, frame_total, has_dropouts,
                    output ready);
endinterface

interface drafa_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [drafa_pkg::CFG_IDX_BITS-1:0]         index;
    drafa_pkg::t_cfg_data                       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/drafa_div.sv
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
module drafa_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  drafa_pkg::t_start   i_dividend,
    input  drafa_pkg::t_sample  i_divisor,
    output drafa_pkg::t_div_res o_res
);

    logic               r_busy, n_busy;
    drafa_pkg::t_cnt    r_cnt, n_cnt;
    drafa_pkg::t_start  r_quo, n_quo;
    drafa_pkg::t_sample r_rem, n_rem;
    drafa_pkg::t_sample r_div, n_div;

    logic [drafa_pkg::LINE_SAMPLE_BITS:0] trial;
    logic [drafa_pkg::LINE_SAMPLE_BITS:0] diff;
    logic                                 fits;

    always_comb begin
        trial = {r_rem, r_quo[drafa_pkg::START_BITS-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = drafa_pkg::CNT_BITS'(drafa_pkg::START_BITS);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[drafa_pkg::START_BITS-2:0], fits};
            n_rem = fits ? diff[drafa_pkg::LINE_SAMPLE_BITS-1:0]
                         : trial[drafa_pkg::LINE_SAMPLE_BITS-1:0];
            n_cnt = r_cnt - drafa_pkg::CNT_BITS'(1);
            if (r_cnt == drafa_pkg::CNT_BITS'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    // done marks the cycle of the final step; results settle at that edge
    assign o_res.done = r_busy && (r_cnt == drafa_pkg::CNT_BITS'(1));
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

// File: hdl/dropout_run_area_filter_accumulator.sv
// Run item: the divider splits the start (DIVIDE), filter and clamp are registered
//   (FILTER), and the result (if any) goes to the output register (COMMIT).
// Frame end: statistics registered in COMMIT, straight after accept in IDLE.
// Rate set by the bit-serial divider, one quotient bit per cycle; a stalled
//   output holds the commit stage. Input ready only in IDLE; config port is always ready.
// Reset (i_rst_n low, synchronous): config to defaults, accumulators cleared, output empty.
`default_nettype none

module dropout_run_area_filter_accumulator (
    input  wire           i_clk,
    input  wire           i_rst_n,
    drafa_in_if.sink      i_in,
    drafa_out_if.source   o_out,
    drafa_cfg_if.sink     i_cfg
);

    localparam int LSB = drafa_pkg::LINE_SAMPLE_BITS;
    localparam int SUM_BITS = drafa_pkg::LAST_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    drafa_pkg::t_sample   r_spl;
    drafa_pkg::t_cfg_data r_fal, r_lal, r_as, r_ae;
    logic                 r_vis, r_det;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spl <= drafa_pkg::SPL_RESET;
            r_fal <= '1;
            r_lal <= '1;
            r_as  <= '1;
            r_ae  <= '1;
            r_vis <= 1'b0;
            r_det <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                drafa_pkg::CFG_SAMPLES_PER_LINE:  r_spl <= i_cfg.data[LSB-1:0];
                drafa_pkg::CFG_FIRST_ACTIVE_LINE: r_fal <= i_cfg.data;
                drafa_pkg::CFG_LAST_ACTIVE_LINE:  r_lal <= i_cfg.data;
                drafa_pkg::CFG_ACTIVE_START:      r_as  <= i_cfg.data;
                drafa_pkg::CFG_ACTIVE_END:        r_ae  <= i_cfg.data;
                drafa_pkg::CFG_VISIBLE_MODE:      r_vis <= i_cfg.data[0];
                drafa_pkg::CFG_COLLECT_DETAIL:    r_det <= i_cfg.data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    drafa_pkg::t_state   r_state, n_state;
    drafa_pkg::t_div_res div_res;

    logic in_accept;
    logic div_start;
    logic out_busy;      // output register holds a beat that is not taken
    logic commit_go;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_busy  = o_out.valid && !o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            drafa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in.req_type == drafa_pkg::REQ_FRAME_END)
                            ? drafa_pkg::ST_COMMIT : drafa_pkg::ST_DIVIDE;
                end
            end
            drafa_pkg::ST_DIVIDE: begin
                if (div_res.done) begin
                    n_state = drafa_pkg::ST_FILTER;
                end
            end
            drafa_pkg::ST_FILTER: n_state = drafa_pkg::ST_COMMIT;
            drafa_pkg::ST_COMMIT: begin
                if (!out_busy) begin
                    n_state = drafa_pkg::ST_IDLE;
                end
            end
            default: n_state = drafa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        commit_go  = 1'b0;
        case (r_state)
            drafa_pkg::ST_IDLE:   i_in.ready = 1'b1;
            drafa_pkg::ST_COMMIT: commit_go  = !out_busy;
            default: ;
        endcase
    end

    assign div_start = in_accept && (i_in.req_type == drafa_pkg::REQ_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drafa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Item capture and start split (line = start / spl, sample = remainder)
    // ---------------------------------------------------------------
    logic              r_type;
    drafa_pkg::t_frame r_frame;
    drafa_pkg::t_len   r_len;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_type  <= i_in.req_type;
            r_frame <= i_in.frame_id;
            r_len   <= i_in.run_length;
        end
    end

    drafa_pkg::t_sample divisor;
    assign divisor = (r_spl == '0) ? LSB'(1) : r_spl;  // zero divisor acts as one

    drafa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.run_start),
        .i_divisor  (divisor),
        .o_res      (div_res)
    );

    // ---------------------------------------------------------------
    // Area filter and clamp (FILTER state)
    // ---------------------------------------------------------------
    drafa_pkg::t_start line;
    logic [SUM_BITS-1:0] sample, s_end, act_s, act_e, cs, ce, kept_w;
    logic line_en, samp_en, line_ok, samp_ok, clamp;

    always_comb begin
        line    = div_res.quo;
        sample  = SUM_BITS'(div_res.rem);
        s_end   = sample + SUM_BITS'(r_len);
        act_s   = SUM_BITS'(r_as[LSB-1:0]);
        act_e   = SUM_BITS'(r_ae[LSB-1:0]);
        // a negative bound turns off its window
        line_en = !r_fal[LSB] && !r_lal[LSB];
        samp_en = !r_as[LSB] && !r_ae[LSB];
        line_ok = !(r_vis && line_en)
               || ((line >= drafa_pkg::t_start'(r_fal[LSB-1:0]))
                && (line <= drafa_pkg::t_start'(r_lal[LSB-1:0])));
        samp_ok = !(r_vis && samp_en) || ((sample < act_e) && (s_end > act_s));
        clamp   = r_vis && samp_en;
        cs      = (clamp && (act_s > sample)) ? act_s : sample;
        ce      = (clamp && (act_e < s_end)) ? act_e : s_end;
        // inverted window leaves nothing, run still counts
        kept_w  = (ce > cs) ? (ce - cs) : '0;
    end

    logic               r_keep;
    drafa_pkg::t_sample r_cs;
    drafa_pkg::t_len    r_kept;
    drafa_pkg::t_line   r_line;

    always_ff @(posedge i_clk) begin
        if (r_state == drafa_pkg::ST_FILTER) begin
            r_keep <= line_ok && samp_ok;
            r_cs   <= cs[LSB-1:0];
            r_kept <= kept_w[drafa_pkg::LEN_BITS-1:0];
            r_line <= (line > drafa_pkg::t_start'({drafa_pkg::LINE_BITS{1'b1}}))
                    ? '1 : line[drafa_pkg::LINE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Frame accumulators and output register (COMMIT state)
    // ---------------------------------------------------------------
    drafa_pkg::t_runs  r_runs;
    drafa_pkg::t_total r_total;
    logic [drafa_pkg::TOTAL_BITS:0] total_sum;
    logic is_end, emit_detail;

    assign is_end      = (r_type == drafa_pkg::REQ_FRAME_END);
    assign total_sum   = {1'b0, r_total} + (drafa_pkg::TOTAL_BITS + 1)'(r_kept);
    assign emit_detail = !is_end && r_keep && r_det && (r_kept != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs  <= '0;
            r_total <= '0;
        end else if (commit_go) begin
            if (is_end) begin
                r_runs  <= '0;
                r_total <= '0;
            end else if (r_keep) begin
                if (r_runs != '1) begin
                    r_runs <= r_runs + drafa_pkg::RUNS_BITS'(1);
                end
                r_total <= total_sum[drafa_pkg::TOTAL_BITS]
                         ? '1 : total_sum[drafa_pkg::TOTAL_BITS-1:0];
            end
        end
    end

    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (commit_go && (is_end || emit_detail)) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go && (is_end || emit_detail)) begin
            o_out.out_frame <= r_frame;
            if (is_end) begin
                o_out.result_kind  <= drafa_pkg::KIND_STATS;
                o_out.line_index   <= '0;
                o_out.first_sample <= '0;
                o_out.last_sample  <= '0;
                o_out.kept_length  <= '0;
                o_out.frame_runs   <= r_runs;
                o_out.frame_total  <= r_total;
                o_out.has_dropouts <= (r_runs != '0);
            end else begin
                o_out.result_kind  <= drafa_pkg::KIND_DETAIL;
                o_out.line_index   <= r_line;
                o_out.first_sample <= r_cs;
                o_out.last_sample  <= drafa_pkg::t_last'(r_cs) + drafa_pkg::t_last'(r_kept)
                                    - drafa_pkg::t_last'(1);
                o_out.kept_length  <= r_kept;
                o_out.frame_runs   <= '0;
                o_out.frame_total  <= '0;
                o_out.has_dropouts <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_ovalid;

endmodule

`default_nettype wire

// File: hdl/drafa_chk.sv
`default_nettype none
`include "dropout_run_area_filter_accumulator_defines.svh"

module drafa_chk (
    input wire           i_clk,
    input wire           i_rst_n,
    drafa_out_if.source  o_out
);

    logic is_stats, is_detail;
    assign is_stats  = o_out.valid && (o_out.result_kind == drafa_pkg::KIND_STATS);
    assign is_detail = o_out.valid && (o_out.result_kind == drafa_pkg::KIND_DETAIL);

    // stalled beat holds
    `DRAFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.out_frame) && $stable(o_out.result_kind) && $stable(o_out.frame_total) && $stable(o_out.kept_length))

    `DRAFA_ASSERT_NOW(a_stats_flag, i_clk, i_rst_n, is_stats, (o_out.has_dropouts == (o_out.frame_runs != '0)) && (o_out.kept_length == '0) && (o_out.line_index == '0))

    `DRAFA_ASSERT_NOW(a_detail_clean, i_clk, i_rst_n, is_detail, (o_out.kept_length != '0) && (o_out.frame_runs == '0) && (o_out.frame_total == '0) && !o_out.has_dropouts)

    `DRAFA_ASSERT_NOW(a_detail_span, i_clk, i_rst_n, is_detail, o_out.last_sample == (drafa_pkg::t_last'(o_out.first_sample) + drafa_pkg::t_last'(o_out.kept_length) - drafa_pkg::t_last'(1)))

endmodule

bind dropout_run_area_filter_accumulator drafa_chk u_drafa_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);

`default_nettype wire
